/* src/jls_pkg.sv */
// shared constants and codes for the jacobi solver core
package jls_pkg;

    localparam int ORDER_DEF   = 8;
    localparam int VALUE_W     = 32;
    localparam int FRAC_BITS   = 24;
    localparam int ITER_W      = 16;
    localparam int TOL_W       = 31;
    localparam int ROW_W       = 3;
    localparam int NUM_W       = 40;

    localparam logic [ITER_W-1:0] MAX_ITER_RST = 16'd100;
    localparam logic [TOL_W-1:0]  TOL_RST      = 31'd17;

    typedef enum logic [1:0] {
        FUNC_LOAD_A = 2'd0,
        FUNC_LOAD_B = 2'd1,
        FUNC_LOAD_X = 2'd2,
        FUNC_SOLVE  = 2'd3
    } func_t;

    localparam logic CFG_MAX_ITER = 1'b0;
    localparam logic CFG_TOL      = 1'b1;

endpackage

/* src/jacobi_linear_solver_core.sv */
// top level of the jacobi iteration solver for A x = b in signed Q8.24
// Loads (matrix element, rhs element, guess element) are taken while idle
// and do not stall the input. A solve beat first checks the diagonal, then
// runs sweeps unless a diagonal element is zero or the sweep limit is zero.
// Each unknown of a sweep takes ORDER reads of row and guess from the
// memories, with the diagonal product kept out of the sum, a drain of the
// multiply and accumulate pipeline with the numerator registered, a divider
// load, 63 radix-2 divider steps, which set the pace, and the taking of the
// quotient. A sweep ends with a copy of the new vector into the solution
// memory. The ORDER results then leave one beat at a time, each held until
// it is taken. The input is stalled from the solve beat until the last
// result beat is taken. The solution memory is kept after a solve, so a
// later solve continues from it.
module jacobi_linear_solver_core #(
    parameter int ORDER = jls_pkg::ORDER_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         func,
    input  logic [jls_pkg::ROW_W-1:0]          row,
    input  logic [jls_pkg::ROW_W-1:0]          col,
    input  logic signed [jls_pkg::VALUE_W-1:0] value,
    // result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [jls_pkg::ROW_W-1:0]          index,
    output logic signed [jls_pkg::VALUE_W-1:0] solution,
    output logic                               converged,
    output logic [jls_pkg::ITER_W-1:0]         sweeps_used,
    output logic                               divide_error,
    output logic                               last,
    // configuration writes
    input  logic                               cfg_write,
    input  logic                               cfg_index,
    input  logic [jls_pkg::TOL_W-1:0]          cfg_data
);

    localparam int IDXW  = $clog2(ORDER);
    localparam int AW    = $clog2(ORDER * ORDER);
    localparam int VW    = jls_pkg::VALUE_W;
    localparam int ACC_W = 48;
    localparam int NW    = jls_pkg::NUM_W;
    localparam logic [IDXW-1:0] IDX_LAST = IDXW'(ORDER - 1);

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b000_0000_0001,
        ST_DCHK_RD  = 11'b000_0000_0010,
        ST_DCHK_CK  = 11'b000_0000_0100,
        ST_MAC      = 11'b000_0000_1000,
        ST_DRAIN    = 11'b000_0001_0000,
        ST_DIV      = 11'b000_0010_0000,
        ST_COPY_RD  = 11'b000_0100_0000,
        ST_COPY_WR  = 11'b000_1000_0000,
        ST_EMIT_RD  = 11'b001_0000_0000,
        ST_EMIT_LD  = 11'b010_0000_0000,
        ST_EMIT_OUT = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [jls_pkg::ITER_W-1:0] max_iter_reg;
    logic [jls_pkg::TOL_W-1:0]  tol_reg;

    // loop control and solve status
    logic [IDXW-1:0]            i_reg, i_next;
    logic [IDXW-1:0]            j_reg, j_next;
    logic                       err_reg, err_next;
    logic                       conv_reg, conv_next;
    logic [jls_pkg::ITER_W-1:0] sweeps_reg, sweeps_next;
    logic [VW-1:0]              worst_reg, worst_next;
    logic                       ovalid_reg, ovalid_next;

    // multiply and accumulate pipeline
    logic                     rd_v_reg, rd_v_next;
    logic [IDXW-1:0]          rd_j_reg;
    logic                     prod_v_reg, prod_v_next;
    logic signed [63:0]       prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [VW-1:0]     diag_reg;
    logic signed [VW-1:0]     xold_reg;
    logic signed [VW-1:0]     sol_reg;
    logic signed [NW-1:0]     num_reg;
    logic [ORDER-1:0]         cur_vld_reg, cur_vld_next;
    logic [IDXW-1:0]          cur_raddr_q;

    // memory ports
    logic            a_we, b_we, cur_we, nxt_we;
    logic [AW-1:0]   a_waddr, a_raddr;
    logic [IDXW-1:0] b_waddr, cur_waddr, cur_raddr, nxt_waddr, nxt_raddr;
    logic [VW-1:0]   cur_wdata, nxt_wdata;
    logic [VW-1:0]   a_rdata, b_rdata, cur_rdata, nxt_rdata;

    // divider
    logic               div_start, div_done;
    logic [VW-1:0]      div_quot;

    // combinational helpers
    logic                    in_acc, out_acc;
    logic                    row_ok, col_ok;
    logic [IDXW-1:0]         row_i, col_i;
    logic signed [VW-1:0]    x_val;
    logic signed [63:0]      prod_shift;
    logic signed [ACC_W:0]   num_wide;
    logic signed [NW-1:0]    num_clamp;
    logic signed [VW:0]      diff;
    logic [VW-1:0]           diff_abs;
    logic                    pipe_empty;

    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = ovalid_reg && !out_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign row_ok   = (32'(row) < ORDER);
    assign col_ok   = (32'(col) < ORDER);
    assign row_i    = IDXW'(row);
    assign col_i    = IDXW'(col);

    // guess entries never written since reset read as zero
    assign x_val = cur_vld_reg[cur_raddr_q] ? cur_rdata : '0;

    assign prod_shift = prod_reg >>> jls_pkg::FRAC_BITS;
    assign pipe_empty = !rd_v_reg && !prod_v_reg;

    // numerator b - sum, clamped to +-2^38
    always_comb
    begin
        num_wide = {{(ACC_W + 1 - VW){b_rdata[VW-1]}}, b_rdata} - {acc_reg[ACC_W-1], acc_reg};
        if (num_wide > (ACC_W + 1)'(64'sd1 <<< 38))
        begin
            num_clamp = NW'(64'sd1 <<< 38);
        end
        else if (num_wide < -((ACC_W + 1)'(64'sd1 <<< 38)))
        begin
            num_clamp = -(NW'(64'sd1 <<< 38));
        end
        else
        begin
            num_clamp = num_wide[NW-1:0];
        end
    end

    assign diff     = {div_quot[VW-1], div_quot} - {xold_reg[VW-1], xold_reg};
    assign diff_abs = diff[VW] ? VW'(-diff) : diff[VW-1:0];

    // memory addressing
    always_comb
    begin
        a_we      = in_acc && (func == jls_pkg::FUNC_LOAD_A) && row_ok && col_ok;
        a_waddr   = AW'(AW'(row_i) * AW'(ORDER)) + AW'(col_i);
        b_we      = in_acc && (func == jls_pkg::FUNC_LOAD_B) && row_ok;
        b_waddr   = row_i;
        cur_we    = 1'b0;
        cur_waddr = row_i;
        cur_wdata = value;
        nxt_we    = 1'b0;
        nxt_waddr = i_reg;
        nxt_wdata = div_quot;
        nxt_raddr = j_reg;
        cur_raddr = j_reg;
        a_raddr   = AW'(AW'(i_reg) * AW'(ORDER)) + AW'(j_reg);
        if (state_reg == ST_DCHK_RD)
        begin
            a_raddr = AW'(AW'(j_reg) * AW'(ORDER)) + AW'(j_reg);
        end
        if (in_acc && (func == jls_pkg::FUNC_LOAD_X) && row_ok)
        begin
            cur_we = 1'b1;
        end
        if (state_reg == ST_COPY_WR)
        begin
            cur_we    = 1'b1;
            cur_waddr = j_reg;
            cur_wdata = nxt_rdata;
        end
        if ((state_reg == ST_DIV) && div_done)
        begin
            nxt_we = 1'b1;
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        err_next     = err_reg;
        conv_next    = conv_reg;
        sweeps_next  = sweeps_reg;
        worst_next   = worst_reg;
        ovalid_next  = ovalid_reg;
        rd_v_next    = 1'b0;
        acc_next     = acc_reg;
        cur_vld_next = cur_vld_reg;
        div_start    = 1'b0;

        if (prod_v_reg)
        begin
            acc_next = acc_reg + prod_shift[ACC_W-1:0];
        end
        if (cur_we)
        begin
            cur_vld_next[cur_waddr] = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (func == jls_pkg::FUNC_SOLVE))
                begin
                    err_next    = 1'b0;
                    conv_next   = 1'b0;
                    sweeps_next = '0;
                    j_next      = '0;
                    state_next  = ST_DCHK_RD;
                end
            end
            ST_DCHK_RD:
            begin
                state_next = ST_DCHK_CK;
            end
            ST_DCHK_CK:
            begin
                err_next = err_reg || (a_rdata == '0);
                if (j_reg == IDX_LAST)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    acc_next   = '0;
                    worst_next = '0;
                    if (err_next || (max_iter_reg == '0))
                    begin
                        state_next = ST_EMIT_RD;
                    end
                    else
                    begin
                        state_next = ST_MAC;
                    end
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_DCHK_RD;
                end
            end
            ST_MAC:
            begin
                rd_v_next = 1'b1;
                if (j_reg == IDX_LAST)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (pipe_empty)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (diff_abs > worst_reg)
                    begin
                        worst_next = diff_abs;
                    end
                    j_next = '0;
                    if (i_reg == IDX_LAST)
                    begin
                        state_next = ST_COPY_RD;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        acc_next   = '0;
                        state_next = ST_MAC;
                    end
                end
            end
            ST_COPY_RD:
            begin
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR:
            begin
                if (j_reg == IDX_LAST)
                begin
                    sweeps_next = sweeps_reg + 1'b1;
                    j_next      = '0;
                    i_next      = '0;
                    acc_next    = '0;
                    worst_next  = '0;
                    if (worst_reg < {1'b0, tol_reg})
                    begin
                        conv_next  = 1'b1;
                        state_next = ST_EMIT_RD;
                    end
                    else if (sweeps_next >= max_iter_reg)
                    begin
                        state_next = ST_EMIT_RD;
                    end
                    else
                    begin
                        state_next = ST_MAC;
                    end
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_COPY_RD;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                ovalid_next = 1'b1;
                state_next  = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                if (out_acc)
                begin
                    ovalid_next = 1'b0;
                    if (j_reg == IDX_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            max_iter_reg <= jls_pkg::MAX_ITER_RST;
            tol_reg      <= jls_pkg::TOL_RST;
            i_reg        <= '0;
            j_reg        <= '0;
            err_reg      <= 1'b0;
            conv_reg     <= 1'b0;
            sweeps_reg   <= '0;
            worst_reg    <= '0;
            ovalid_reg   <= 1'b0;
            rd_v_reg     <= 1'b0;
            prod_v_reg   <= 1'b0;
            cur_vld_reg  <= '0;
            cur_raddr_q  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            err_reg     <= err_next;
            conv_reg    <= conv_next;
            sweeps_reg  <= sweeps_next;
            worst_reg   <= worst_next;
            ovalid_reg  <= ovalid_next;
            rd_v_reg    <= rd_v_next;
            prod_v_reg  <= prod_v_next;
            cur_vld_reg <= cur_vld_next;
            cur_raddr_q <= cur_raddr;
            if (cfg_write)
            begin
                if (cfg_index == jls_pkg::CFG_MAX_ITER)
                begin
                    max_iter_reg <= cfg_data[jls_pkg::ITER_W-1:0];
                end
                else
                begin
                    tol_reg <= cfg_data;
                end
            end
        end
    end

    // off-diagonal products only feed the accumulator
    assign prod_v_next = rd_v_reg && (rd_j_reg != i_reg);

    always_ff @(posedge clk)
    begin
        rd_j_reg <= j_reg;
        acc_reg  <= acc_next;
        num_reg  <= num_clamp;
        prod_reg <= $signed(a_rdata) * x_val;
        if (rd_v_reg && (rd_j_reg == i_reg))
        begin
            diag_reg <= a_rdata;
            xold_reg <= x_val;
        end
        if (state_reg == ST_EMIT_LD)
        begin
            sol_reg <= x_val;
        end
    end

    jls_ram #(.WIDTH(VW), .DEPTH(ORDER * ORDER)) u_a_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (value),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    jls_ram #(.WIDTH(VW), .DEPTH(ORDER)) u_b_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (value),
        .raddr (i_reg),
        .rdata (b_rdata)
    );

    jls_ram #(.WIDTH(VW), .DEPTH(ORDER)) u_cur_ram (
        .clk   (clk),
        .we    (cur_we),
        .waddr (cur_waddr),
        .wdata (cur_wdata),
        .raddr (cur_raddr),
        .rdata (cur_rdata)
    );

    jls_ram #(.WIDTH(VW), .DEPTH(ORDER)) u_nxt_ram (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .raddr (nxt_raddr),
        .rdata (nxt_rdata)
    );

    // start is delayed by a register so the divider sees it with the registered numerator
    logic div_start_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_start_q <= 1'b0;
        end
        else
        begin
            div_start_q <= div_start;
        end
    end

    jls_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_q),
        .num   (num_reg),
        .diag  (diag_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // result beat
    assign out_valid    = ovalid_reg;
    assign index        = jls_pkg::ROW_W'(j_reg);
    assign solution     = sol_reg;
    assign converged    = conv_reg;
    assign sweeps_used  = sweeps_reg;
    assign divide_error = err_reg;
    assign last         = (j_reg == IDX_LAST);

`ifndef SYNTHESIS
    // no input beat is taken while a result beat is pending
    a_stall_on_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input not stalled during result beat");

    // a zero diagonal means no sweep was run
    a_err_no_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && divide_error) |-> (sweeps_used == '0) && !converged)
        else $error("sweeps reported with zero diagonal");

    // convergence needs at least one sweep
    a_conv_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && converged) |-> (sweeps_used != '0))
        else $error("converged without a sweep");

    // the divider only finishes while the sequencer waits for it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider result outside divide state");
`endif

endmodule

/* src/jls_ram.sv */
// generic single write port ram with registered read
module jls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/jls_div.sv */
// sequential signed divider: (num << 24) / diag, truncated, saturated to 32 bits
module jls_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [jls_pkg::NUM_W-1:0]    num,
    input  logic signed [jls_pkg::VALUE_W-1:0]  diag,
    output logic                                done,
    output logic [jls_pkg::VALUE_W-1:0]         quot
);

    localparam int MAG_W   = jls_pkg::NUM_W - 1;
    localparam int QW      = MAG_W + jls_pkg::FRAC_BITS;
    localparam int CW      = $clog2(QW);
    localparam int VW      = jls_pkg::VALUE_W;
    localparam int NUM_W_L = jls_pkg::NUM_W;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [QW-1:0] q_reg, q_next;
    logic [VW-1:0] dsr_reg, dsr_next;
    logic          neg_reg, neg_next;

    logic [NUM_W_L-1:0] num_neg;
    logic [VW:0]   shifted;
    logic [VW-1:0] diag_mag;

    always_comb
    begin
        num_neg   = -num;
        diag_mag  = diag[VW-1] ? -diag : diag;
        shifted   = {rem_reg, q_reg[QW-1]};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(QW - 1);
            rem_next  = '0;
            q_next    = {(num[NUM_W_L-1] ? num_neg[MAG_W-1:0] : num[MAG_W-1:0]),
                         {jls_pkg::FRAC_BITS{1'b0}}};
            dsr_next  = diag_mag;
            neg_next  = num[NUM_W_L-1] ^ diag[VW-1];
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_next = VW'(shifted - {1'b0, dsr_reg});
                q_next   = {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[VW-1:0];
                q_next   = {q_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // saturate the magnitude quotient with its sign
    always_comb
    begin
        if (neg_reg)
        begin
            if (q_reg > QW'(64'h8000_0000))
            begin
                quot = 32'h8000_0000;
            end
            else
            begin
                quot = -q_reg[VW-1:0];
            end
        end
        else if (q_reg > QW'(64'h7FFF_FFFF))
        begin
            quot = 32'h7FFF_FFFF;
        end
        else
        begin
            quot = q_reg[VW-1:0];
        end
    end

    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

endmodule
